FILE: design/bpe_pkg.sv
// ----------------------------------------------------------------------------
// bpe_pkg
// Shared types and constants for the bit-vector edit distance block.
// ----------------------------------------------------------------------------
package bpe_pkg;

	localparam int WORD_BITS     = 64;
	localparam int ALPHABET_SIZE = 256;
	localparam int COUNT_BITS    = 16;

	localparam int SYM_BITS   = $clog2(ALPHABET_SIZE);
	localparam int PLEN_BITS  = $clog2(WORD_BITS + 1);
	localparam int WIDX_BITS  = $clog2(WORD_BITS);
	localparam int SCORE_BITS = COUNT_BITS + 1;
	localparam int DIST_BITS  = 16;
	localparam int CMD_BITS   = 2;
	localparam int IN_BITS    = 16;
	localparam int OUT_BITS   = 24;
	localparam int CFG_BITS   = 16;

	localparam logic [SCORE_BITS-1:0] SCORE_MAX = '1;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [SCORE_BITS-1:0] COUNT_MAX_EXT = {1'b0, COUNT_MAX};
	localparam logic [SCORE_BITS-1:0] OUT_MAX_EXT = SCORE_BITS'({DIST_BITS{1'b1}});
	localparam logic [PLEN_BITS-1:0] PLEN_FULL = PLEN_BITS'(WORD_BITS);

	typedef enum logic [CMD_BITS-1:0] {
		CMD_PATTERN = 2'd0,
		CMD_TEXT    = 2'd1,
		CMD_FINISH  = 2'd2
	} cmd_t;

	typedef enum logic {
		REG_CAP_ENABLE = 1'b0,
		REG_CAP_LIMIT  = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic ph_last;
		logic mh_last;
	} step_flags_t;

endpackage

FILE: design/bpe_ram.sv
// ----------------------------------------------------------------------------
// bpe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bpe_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: design/bpe_step.sv
// ----------------------------------------------------------------------------
// bpe_step
// One column update of the bit-vector recurrence: new vertical deltas and
// the horizontal delta flags at the last pattern row.
// ----------------------------------------------------------------------------
module bpe_step (
	input  logic [bpe_pkg::WORD_BITS-1:0] eq,
	input  logic [bpe_pkg::WORD_BITS-1:0] pv,
	input  logic [bpe_pkg::WORD_BITS-1:0] mv,
	input  logic [bpe_pkg::WIDX_BITS-1:0] last_idx,
	output logic [bpe_pkg::WORD_BITS-1:0] pv_next,
	output logic [bpe_pkg::WORD_BITS-1:0] mv_next,
	output bpe_pkg::step_flags_t          flags
);

	logic [bpe_pkg::WORD_BITS-1:0] xv;
	logic [bpe_pkg::WORD_BITS-1:0] xh;
	logic [bpe_pkg::WORD_BITS-1:0] ph;
	logic [bpe_pkg::WORD_BITS-1:0] mh;
	logic [bpe_pkg::WORD_BITS-1:0] ph_sh;
	logic [bpe_pkg::WORD_BITS-1:0] mh_sh;

	always_comb begin
		xv    = eq | mv;
		xh    = (((eq & pv) + pv) ^ pv) | eq;
		ph    = mv | ~(xh | pv);
		mh    = pv & xh;
		ph_sh = {ph[bpe_pkg::WORD_BITS-2:0], 1'b1};
		mh_sh = {mh[bpe_pkg::WORD_BITS-2:0], 1'b0};
		pv_next = mh_sh | ~(xv | ph_sh);
		mv_next = ph_sh & xv;
		flags.ph_last = ph[last_idx];
		flags.mh_last = mh[last_idx];
	end

endmodule

FILE: design/bit_parallel_edit_distance.sv
// ----------------------------------------------------------------------------
// bit_parallel_edit_distance
// Levenshtein distance of a streamed text against a pattern of up to 64
// bytes, single-word bit-vector recurrence, one symbol per cycle.
// ----------------------------------------------------------------------------
// Result path: a finish item's result is registered from stage s1 into the output
// register and offered on m_tvalid from there.
// Throughput: one item per cycle; the equality mask RAM read (registered,
// issued at acceptance) and one 64-bit add set the cycle.
// A finish item waits in the stage only while the output register is full.
// Reset: asynchronous, clears all control state and mask valid bits at once;
// no clearing pass. Finish also clears all mask valid bits at once.
// ----------------------------------------------------------------------------
module bit_parallel_edit_distance (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [bpe_pkg::IN_BITS-1:0]    s_tdata,   // command[1:0], symbol[9:2]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [bpe_pkg::OUT_BITS-1:0]   m_tdata,   // distance[15:0], pattern_overflow[16]
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [bpe_pkg::CFG_BITS-1:0]   cfg_data
);

	localparam int W = bpe_pkg::WORD_BITS;

	logic                              in_fire;
	logic [bpe_pkg::CMD_BITS-1:0]      in_cmd;
	logic [bpe_pkg::SYM_BITS-1:0]      in_sym;

	logic                              valid_s1;
	logic [bpe_pkg::CMD_BITS-1:0]      cmd_s1;
	logic [bpe_pkg::SYM_BITS-1:0]      sym_s1;
	logic                              byp_s1;
	logic [W-1:0]                      byp_data_s1;

	logic                              cap_en_q;
	logic [bpe_pkg::DIST_BITS-1:0]     cap_lim_q;
	logic [bpe_pkg::ALPHABET_SIZE-1:0] mask_valid_q;
	logic [bpe_pkg::PLEN_BITS-1:0]     plen_q;
	logic [W-1:0]                      pv_q;
	logic [W-1:0]                      mv_q;
	logic [bpe_pkg::SCORE_BITS-1:0]    score_q;
	logic [bpe_pkg::COUNT_BITS-1:0]    tcount_q;
	logic                              ovf_q;

	logic                              out_valid_q;
	logic [bpe_pkg::DIST_BITS-1:0]     out_dist_q;
	logic                              out_ovf_q;

	logic                              out_free;
	logic                              s1_go;
	logic                              s1_do;
	logic                              finish_fire;
	logic                              pat_fire;
	logic                              text_fire;

	logic [W-1:0]                      rd_data;
	logic [W-1:0]                      eq_cur;
	logic                              wr_en;
	logic [W-1:0]                      wr_data;

	logic [W-1:0]                      pv_next;
	logic [W-1:0]                      mv_next;
	bpe_pkg::step_flags_t              flags;
	logic [bpe_pkg::WIDX_BITS-1:0]     last_idx;

	logic [bpe_pkg::SCORE_BITS-1:0]    score_pat;
	logic [bpe_pkg::SCORE_BITS-1:0]    score_txt;
	logic [bpe_pkg::SCORE_BITS-1:0]    dist_w;

	assign in_cmd  = s_tdata[bpe_pkg::CMD_BITS-1:0];
	assign in_sym  = s_tdata[bpe_pkg::CMD_BITS +: bpe_pkg::SYM_BITS];

	assign out_free = !out_valid_q || m_tready;
	assign s1_go    = !(cmd_s1 == bpe_pkg::CMD_FINISH) || out_free;
	assign s_tready = !valid_s1 || s1_go;
	assign in_fire  = s_tvalid && s_tready;
	assign s1_do    = valid_s1 && s1_go;

	assign finish_fire = s1_do && (cmd_s1 == bpe_pkg::CMD_FINISH);
	assign pat_fire    = s1_do && (cmd_s1 == bpe_pkg::CMD_PATTERN);
	assign text_fire   = s1_do && (cmd_s1 == bpe_pkg::CMD_TEXT);

	// mask lookup: invalid entry reads as zero, same-entry write last cycle bypasses
	always_comb begin
		eq_cur = '0;
		if (mask_valid_q[sym_s1]) begin
			eq_cur = byp_s1 ? byp_data_s1 : rd_data;
		end
	end

	assign wr_en   = pat_fire && (tcount_q == '0) && (plen_q != bpe_pkg::PLEN_FULL);
	assign wr_data = eq_cur | (W'(1) << plen_q[bpe_pkg::WIDX_BITS-1:0]);

	bpe_ram #(
		.WIDTH (W),
		.DEPTH (bpe_pkg::ALPHABET_SIZE)
	) u_mask_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (sym_s1),
		.wdata (wr_data),
		.re    (in_fire),
		.raddr (in_sym),
		.rdata (rd_data)
	);

	assign last_idx = bpe_pkg::WIDX_BITS'(plen_q - 1'b1);

	bpe_step u_step (
		.eq       (eq_cur),
		.pv       (pv_q),
		.mv       (mv_q),
		.last_idx (last_idx),
		.pv_next  (pv_next),
		.mv_next  (mv_next),
		.flags    (flags)
	);

	always_comb begin
		score_pat = score_q;
		if (score_q != bpe_pkg::SCORE_MAX) begin
			score_pat = score_q + 1'b1;
		end
		score_txt = score_q;
		if (plen_q == '0) begin
			score_txt = score_pat;
		end else begin
			if (flags.ph_last && score_txt != bpe_pkg::SCORE_MAX) begin
				score_txt = score_txt + 1'b1;
			end
			if (flags.mh_last && score_txt != bpe_pkg::SCORE_MAX && score_txt != '0) begin
				score_txt = score_txt - 1'b1;
			end
		end
	end

	always_comb begin
		dist_w = score_q;
		if (cap_en_q && dist_w > bpe_pkg::SCORE_BITS'(cap_lim_q)) begin
			dist_w = bpe_pkg::SCORE_BITS'(cap_lim_q) + 1'b1;
		end
		if (dist_w > bpe_pkg::COUNT_MAX_EXT) begin
			dist_w = bpe_pkg::COUNT_MAX_EXT;
		end
		if (dist_w > bpe_pkg::OUT_MAX_EXT) begin
			dist_w = bpe_pkg::OUT_MAX_EXT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_en_q  <= 1'b0;
			cap_lim_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bpe_pkg::REG_CAP_ENABLE: cap_en_q  <= cfg_data[0];
				bpe_pkg::REG_CAP_LIMIT:  cap_lim_q <= cfg_data[bpe_pkg::DIST_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			byp_s1   <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
				byp_s1   <= wr_en && (sym_s1 == in_sym);
			end else if (s1_do) begin
				valid_s1 <= 1'b0;
				byp_s1   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_s1      <= in_cmd;
			sym_s1      <= in_sym;
			byp_data_s1 <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_valid_q <= '0;
			plen_q       <= '0;
			pv_q         <= '1;
			mv_q         <= '0;
			score_q      <= '0;
			tcount_q     <= '0;
			ovf_q        <= 1'b0;
		end else if (finish_fire) begin
			mask_valid_q <= '0;
			plen_q       <= '0;
			pv_q         <= '1;
			mv_q         <= '0;
			score_q      <= '0;
			tcount_q     <= '0;
			ovf_q        <= 1'b0;
		end else if (pat_fire) begin
			if (tcount_q == '0) begin
				if (plen_q == bpe_pkg::PLEN_FULL) begin
					ovf_q <= 1'b1;
				end else begin
					mask_valid_q[sym_s1] <= 1'b1;
					plen_q               <= plen_q + 1'b1;
					score_q              <= score_pat;
				end
			end
		end else if (text_fire) begin
			if (tcount_q != bpe_pkg::COUNT_MAX) begin
				tcount_q <= tcount_q + 1'b1;
			end
			score_q <= score_txt;
			if (plen_q != '0) begin
				pv_q <= pv_next;
				mv_q <= mv_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish_fire) begin
			out_dist_q <= dist_w[bpe_pkg::DIST_BITS-1:0];
			out_ovf_q  <= ovf_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(bpe_pkg::OUT_BITS - bpe_pkg::DIST_BITS - 1){1'b0}},
	                   out_ovf_q, out_dist_q};

	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		finish_fire |=> (plen_q == '0 && mask_valid_q == '0 && score_q == '0))
		else $error("job state not cleared after finish");

	a_plen_range: assert property (@(posedge clk) disable iff (!arst_n)
		plen_q <= bpe_pkg::PLEN_FULL)
		else $error("pattern length beyond word width");

	a_bypass_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && byp_s1) |-> mask_valid_q[sym_s1])
		else $error("bypass on an entry that is not valid");

	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(finish_fire))
		else $error("result without a finish item");

	a_pattern_locked: assert property (@(posedge clk) disable iff (!arst_n)
		(pat_fire && tcount_q != '0) |=> $stable(plen_q) && $stable(score_q))
		else $error("pattern item after text changed state");

endmodule
